>>> rtl/cht_pkg.sv
`timescale 1ns / 1ps

package cht_pkg;

   // Fixed field widths of the request and response channels.
   localparam int KEY_W = 31;
   localparam int STATUS_W = 3;
   localparam int SLOT_IDX_W = 6;

   // Default table size.
   localparam int TABLE_SLOTS_DEF = 64;

   // Request types.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_FIND = 1'b1;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL = 3'd2,
      ST_FOUND = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_WALK_RD,
      S_WALK_CHK,
      S_FIND_RD,
      S_FIND_CHK,
      S_DONE
   } state_type;

endpackage

>>> rtl/cht_ram.sv
`timescale 1ns / 1ps

module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cht_home_mod.sv
`timescale 1ns / 1ps

module cht_home_mod #(
   parameter int TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cht_pkg::KEY_W-1:0]      key,
   output logic                           done,
   output logic [$clog2(TABLE_SLOTS)-1:0] home
);

   import cht_pkg::*;

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int RW = KEY_W + 1;
   localparam int PW = KEY_W + RW;
   localparam int SH = KEY_W + AW;
   // Rounded-up reciprocal of the table size, scaled by 2**SH. At this scale
   // the quotient of every 31-bit key comes out exact, and it fits in 32 bits.
   localparam logic [RW-1:0] RECIP =
      RW'(((64'd1 << SH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));
   localparam logic [AW-1:0] SLOTS_LO = AW'(TABLE_SLOTS);

   // Steps in order: key capture, reciprocal multiply, remainder. Only the low
   // AW bits of the quotient matter, since the remainder fits in AW bits.
   logic [KEY_W-1:0] key_ff, key_in;
   logic [AW-1:0]    quot_ff, quot_in;
   logic [AW-1:0]    rem_ff, rem_in;
   logic             stage1_ff, stage1_in;
   logic             stage2_ff, stage2_in;
   logic             done_ff, done_in;
   logic [PW-1:0]    prod;
   logic [AW-1:0]    quot_mul;

   always_comb begin
      key_in = start ? key : key_ff;
      prod = {{RW{1'b0}}, key_ff} * {{KEY_W{1'b0}}, RECIP};
      quot_in = prod[SH +: AW];
      quot_mul = quot_ff * SLOTS_LO;
      rem_in = key_ff[AW-1:0] - quot_mul;
      stage1_in = start;
      stage2_in = stage1_ff;
      done_in = stage2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         stage1_ff <= stage1_in;
         stage2_ff <= stage2_in;
         done_ff <= done_in;
      end
      key_ff <= key_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

>>> rtl/coalesced_hash_table_unit.sv
`timescale 1ns / 1ps

// Coalesced hash table of 31-bit keys in TABLE_SLOTS slots.
// A request on the req_ channel carries req_type (insert or find) and req_key.
// Every request gives exactly one response on the rsp_ channel: rsp_status and
// rsp_slot_index (low six bits of the slot; zero for duplicate, full and not found).
// Both channels use valid/ready; a transfer happens when both are high.
// The home slot (key mod TABLE_SLOTS) comes from a reciprocal multiply in the
// cht_home_mod pipeline. Each slot visited is then a read state, which puts the
// address on the slot memory read port, and a check state on the registered
// read data; the result is then loaded into the output register. An insert
// into a crowded table reads slots on both the probe and the chain walk.
// One request is worked on at a time; req_ready is high while the controller
// is idle, even if a response is still waiting in the output register. If the
// receiver stalls, a finished result waits in the controller until the output
// register frees up. After reset the block clears every slot (used mark off,
// link null), one slot per cycle, so req_ready stays low until the pass is through.
module coalesced_hash_table_unit #(
   parameter int TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [cht_pkg::KEY_W-1:0]        req_key,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cht_pkg::STATUS_W-1:0]     rsp_status,
   output logic [cht_pkg::SLOT_IDX_W-1:0]   rsp_slot_index
);

   import cht_pkg::*;

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int LW = $clog2(TABLE_SLOTS + 1);
   localparam int DW = KEY_W + 1 + LW;
   localparam int XW = (AW > SLOT_IDX_W) ? AW : SLOT_IDX_W;
   localparam logic [LW-1:0] LINK_NULL = LW'(TABLE_SLOTS);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

   state_type state_ff, state_in;

   logic [KEY_W-1:0]      key_ff, key_in;
   logic                  op_ff, op_in;
   logic [AW-1:0]         home_ff, home_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [AW-1:0]         new_ff, new_in;
   logic [LW-1:0]         steps_ff, steps_in;
   logic [AW-1:0]         clr_ff, clr_in;
   status_type            res_status_ff, res_status_in;
   logic [AW-1:0]         res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_IDX_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic                  mod_start;
   logic                  mod_done;
   logic [AW-1:0]         mod_home;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DW-1:0]         wr_data;
   logic [DW-1:0]         rd_data;

   logic [KEY_W-1:0]      rd_key;
   logic                  rd_used;
   logic [LW-1:0]         rd_link;
   logic [AW-1:0]         addr_nxt;
   logic                  link_go;
   logic [XW-1:0]         slot_ext;

   cht_home_mod #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_home (
      .clock(clock),
      .reset(reset),
      .start(mod_start),
      .key(key_in),
      .done(mod_done),
      .home(mod_home)
   );

   // Each word holds {key, used, link}; the link is null when equal to TABLE_SLOTS.
   cht_ram #(
      .WIDTH(DW),
      .DEPTH(TABLE_SLOTS)
   ) u_slots (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   assign rd_key = rd_data[DW-1 -: KEY_W];
   assign rd_used = rd_data[LW];
   assign rd_link = rd_data[LW-1:0];

   // Next slot of the linear probe, wrapping at the end of the table.
   assign addr_nxt = (addr_ff == LAST_SLOT) ? '0 : addr_ff + 1'b1;

   // A chain walk goes on while the step bound holds and the link is not null.
   assign link_go = (steps_ff < LINK_NULL) && (rd_link < LINK_NULL);

   always_comb begin
      state_in = state_ff;
      key_in = key_ff;
      op_in = op_ff;
      home_in = home_ff;
      addr_in = addr_ff;
      new_in = new_ff;
      steps_in = steps_ff;
      clr_in = clr_ff;
      res_status_in = res_status_ff;
      res_slot_in = res_slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in = rsp_slot_ff;
      mod_start = 1'b0;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = {key_ff, 1'b1, rd_link};
      req_ready = 1'b0;
      slot_ext = XW'(res_slot_ff);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = {{KEY_W{1'b0}}, 1'b0, LINK_NULL};
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in = req_key;
               op_in = req_type;
               mod_start = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               home_in = mod_home;
               addr_in = mod_home;
               steps_in = '0;
               state_in = (op_ff == REQ_FIND) ? S_FIND_RD : S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            state_in = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            if (!rd_used) begin
               // Claim the free slot; a slot away from home is then hung
               // on the tail of the home chain.
               wr_en = 1'b1;
               if (addr_ff == home_ff) begin
                  res_status_in = ST_INSERTED;
                  res_slot_in = addr_ff;
                  state_in = S_DONE;
               end else begin
                  new_in = addr_ff;
                  addr_in = home_ff;
                  steps_in = '0;
                  state_in = S_WALK_RD;
               end
            end else if (rd_key == key_ff) begin
               res_status_in = ST_DUPLICATE;
               res_slot_in = '0;
               state_in = S_DONE;
            end else if (addr_nxt == home_ff) begin
               res_status_in = ST_FULL;
               res_slot_in = '0;
               state_in = S_DONE;
            end else begin
               addr_in = addr_nxt;
               state_in = S_PROBE_RD;
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (link_go) begin
               addr_in = rd_link[AW-1:0];
               steps_in = steps_ff + 1'b1;
               state_in = S_WALK_RD;
            end else begin
               wr_en = 1'b1;
               wr_data = {rd_key, rd_used, LW'(new_ff)};
               res_status_in = ST_INSERTED;
               res_slot_in = new_ff;
               state_in = S_DONE;
            end
         end
         S_FIND_RD: begin
            state_in = S_FIND_CHK;
         end
         S_FIND_CHK: begin
            if (rd_used && (rd_key == key_ff)) begin
               res_status_in = ST_FOUND;
               res_slot_in = addr_ff;
               state_in = S_DONE;
            end else if (link_go) begin
               addr_in = rd_link[AW-1:0];
               steps_in = steps_ff + 1'b1;
               state_in = S_FIND_RD;
            end else begin
               res_status_in = ST_NOT_FOUND;
               res_slot_in = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in = slot_ext[SLOT_IDX_W-1:0];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff <= key_in;
      op_ff <= op_in;
      home_ff <= home_in;
      addr_ff <= addr_in;
      new_ff <= new_in;
      steps_ff <= steps_in;
      res_status_ff <= res_status_in;
      res_slot_ff <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

>>> rtl/cht_checker.sv
`timescale 1ns / 1ps

module cht_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_type,
   input logic [cht_pkg::KEY_W-1:0]      req_key,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cht_pkg::STATUS_W-1:0]   rsp_status,
   input logic [cht_pkg::SLOT_IDX_W-1:0] rsp_slot_index
);

   import cht_pkg::*;

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot_index))
      else $error("response changed while stalled");

   // Only inserted and found responses carry a slot number.
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DUPLICATE || rsp_status == ST_FULL
         || rsp_status == ST_NOT_FOUND) |-> rsp_slot_index == '0)
      else $error("nonzero slot on a miss response");

   // An accepted request keeps the block busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one was in work");

   // Reset empties the output and starts the clearing pass.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

endmodule

bind coalesced_hash_table_unit cht_checker u_cht_checker (.*);
